// ----- rtl/core/mbeg_pkg.sv -----
`default_nettype none

package mbeg_pkg;

    typedef struct packed {
        logic [31:0] time_ms;
        logic [31:0] loop_start_ms;
    } tick_t;

    typedef struct packed {
        logic [2:0] event_kind;
        logic [4:0] event_channel;
        logic [6:0] data_first;
        logic [6:0] data_second;
        logic [8:0] led_level;
        logic       last;
    } evt_t;

    localparam logic [2:0] KIND_PROGRAM  = 3'd0;
    localparam logic [2:0] KIND_NOTE_OFF = 3'd1;
    localparam logic [2:0] KIND_CONTROL  = 3'd2;
    localparam logic [2:0] KIND_NOTE_ON  = 3'd3;
    localparam logic [2:0] KIND_LED      = 3'd4;

    typedef enum logic [2:0] {
        REG_ENABLED,
        REG_BPM,
        REG_BAR,
        REG_ACCENT,
        REG_PLAIN,
        REG_CHANNEL,
        REG_VOLUME,
        REG_INSTRUMENT
    } reg_idx_t;

    localparam int DIV_W = 16;
    localparam int DVS_W = 9;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic [DIV_W-1:0] quotient;
        logic [DVS_W-1:0] remainder;
    } div_rsp_t;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_EVAL,
        OP_NOP,
        OP_EMIT,
        OP_DIV_PERIOD,
        OP_DIV_BAR,
        OP_DIV_WAIT,
        OP_TAKE_PERIOD,
        OP_SET_TIMES,
        OP_SET_BAR
    } op_t;

    typedef enum logic [2:0] {
        EV_PROGRAM,
        EV_OFF_ACCENT,
        EV_OFF_PLAIN,
        EV_LED_OFF,
        EV_VOLUME,
        EV_NOTE_ON,
        EV_LED_BEAT,
        EV_NONE
    } ev_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_ITEM,
        COND_DISABLED,
        COND_NO_PROG,
        COND_NO_STOP,
        COND_NO_BEAT,
        COND_DIV_BUSY
    } cond_t;

    typedef logic [4:0] pc_t;

    typedef struct packed {
        op_t   op;
        ev_t   ev;
        cond_t cond;
        pc_t   target;
    } uword_t;

    localparam pc_t STEP_IDLE      = 5'd0;
    localparam pc_t STEP_STOP_TEST = 5'd4;
    localparam pc_t STEP_BEAT_TEST = 5'd8;
    localparam pc_t STEP_WAIT_PER  = 5'd13;
    localparam pc_t STEP_WAIT_BAR  = 5'd17;

    // control store
    function automatic uword_t ucode(input pc_t pc);
        uword_t w;
        w = '{op: OP_IDLE, ev: EV_NONE, cond: COND_ALWAYS, target: STEP_IDLE};
        case (pc)
            5'd0:  w = '{op: OP_IDLE, ev: EV_NONE, cond: COND_NO_ITEM, target: STEP_IDLE};
            5'd1:  w = '{op: OP_EVAL, ev: EV_NONE, cond: COND_DISABLED, target: STEP_IDLE};
            5'd2:  w = '{op: OP_NOP, ev: EV_NONE, cond: COND_NO_PROG, target: STEP_STOP_TEST};
            5'd3:  w = '{op: OP_EMIT, ev: EV_PROGRAM, cond: COND_NEVER, target: STEP_IDLE};
            5'd4:  w = '{op: OP_NOP, ev: EV_NONE, cond: COND_NO_STOP, target: STEP_BEAT_TEST};
            5'd5:  w = '{op: OP_EMIT, ev: EV_OFF_ACCENT, cond: COND_NEVER, target: STEP_IDLE};
            5'd6:  w = '{op: OP_EMIT, ev: EV_OFF_PLAIN, cond: COND_NEVER, target: STEP_IDLE};
            5'd7:  w = '{op: OP_EMIT, ev: EV_LED_OFF, cond: COND_NEVER, target: STEP_IDLE};
            5'd8:  w = '{op: OP_NOP, ev: EV_NONE, cond: COND_NO_BEAT, target: STEP_IDLE};
            5'd9:  w = '{op: OP_EMIT, ev: EV_VOLUME, cond: COND_NEVER, target: STEP_IDLE};
            5'd10: w = '{op: OP_EMIT, ev: EV_NOTE_ON, cond: COND_NEVER, target: STEP_IDLE};
            5'd11: w = '{op: OP_EMIT, ev: EV_LED_BEAT, cond: COND_NEVER, target: STEP_IDLE};
            5'd12: w = '{op: OP_DIV_PERIOD, ev: EV_NONE, cond: COND_NEVER, target: STEP_IDLE};
            5'd13: w = '{op: OP_DIV_WAIT, ev: EV_NONE, cond: COND_DIV_BUSY,
                         target: STEP_WAIT_PER};
            5'd14: w = '{op: OP_TAKE_PERIOD, ev: EV_NONE, cond: COND_NEVER, target: STEP_IDLE};
            5'd15: w = '{op: OP_SET_TIMES, ev: EV_NONE, cond: COND_NEVER, target: STEP_IDLE};
            5'd16: w = '{op: OP_DIV_BAR, ev: EV_NONE, cond: COND_NEVER, target: STEP_IDLE};
            5'd17: w = '{op: OP_DIV_WAIT, ev: EV_NONE, cond: COND_DIV_BUSY,
                         target: STEP_WAIT_BAR};
            5'd18: w = '{op: OP_SET_BAR, ev: EV_NONE, cond: COND_ALWAYS, target: STEP_IDLE};
            default: w = '{op: OP_NOP, ev: EV_NONE, cond: COND_ALWAYS, target: STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/mbeg_div.sv -----
`default_nettype none

module mbeg_div
    import mbeg_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             fits;

    // one restoring step per cycle
    always_comb
    begin
        trial = {rem_reg, quo_reg[DIV_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        fits  = trial >= {1'b0, dvs_reg};

        busy_next  = busy_reg;
        count_next = count_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;

        if (req.start)
        begin
            busy_next  = 1'b1;
            count_next = CNT_W'(DIV_W);
            quo_next   = req.dividend;
            rem_next   = '0;
            dvs_next   = req.divisor;
        end
        else if (busy_reg)
        begin
            quo_next   = {quo_reg[DIV_W-2:0], fits};
            rem_next   = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            count_next = count_reg - CNT_W'(1);
            busy_next  = count_reg != CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp = '{busy: busy_reg, quotient: quo_reg, remainder: rem_reg};

endmodule

`default_nettype wire

// ----- rtl/core/metronome_beat_event_generator_unit.sv -----
// a disabled tick returns to idle after the evaluation step; an enabled tick with no beat after the beat test
// first event of a tick is registered at the first emit step that follows the evaluation step
// a beat tick waits on two 16-step runs of the shared serial divider
// one tick at a time: the next tick is taken once the sequencer is back at its idle step
// reset: config registers take their defaults, beat_in_bar 1, next beat and stop times 0, last instrument 255
// event output register may hold an item while the sequencer works on
`default_nettype none

module metronome_beat_event_generator_unit
    import mbeg_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        tick_valid,
    output logic             tick_stall,
    input  wire tick_t       tick,
    output logic             evt_valid,
    input  wire logic        evt_stall,
    output evt_t             evt,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic [15:0] BEAT_MS_NUM = 16'd60000;
    localparam logic [15:0] TENTH_MUL   = 16'd52429;  // x/10 == x*52429 >> 19 for 16-bit x
    localparam logic [11:0] VOL_MUL     = 12'd2622;   // x/25 == x*2622 >> 16 for x < 4096
    localparam logic [31:0] REARM_MS    = 32'd200;

    // configuration
    logic       enabled_reg;
    logic [8:0] bpm_reg;
    logic [4:0] bar_reg;
    logic [6:0] accent_reg;
    logic [6:0] plain_reg;
    logic [4:0] channel_reg;
    logic [6:0] volume_reg;
    logic [6:0] instr_reg;
    logic       cfg_write;
    reg_idx_t   cfg_idx;

    // sequencer and datapath
    pc_t         pc_reg, pc_next;
    uword_t      uw;
    logic        cond_true;
    logic        out_free;
    logic        emit;
    logic        tick_take;

    logic [31:0] time_reg, time_next;
    logic [31:0] loop_reg, loop_next;
    logic [3:0]  beat_reg, beat_next;
    logic [31:0] next_beat_reg, next_beat_next;
    logic [31:0] next_stop_reg, next_stop_next;
    logic        sounding_reg, sounding_next;
    logic [7:0]  last_instr_reg, last_instr_next;
    logic        prog_reg, prog_next;
    logic        stop_reg, stop_next;
    logic        beat_hit_reg, beat_hit_next;
    logic [15:0] period_reg, period_next;
    logic [12:0] tenth_reg, tenth_next;
    logic        evt_valid_reg, evt_valid_next;
    evt_t        evt_reg, evt_next;
    evt_t        evt_build;

    logic [4:0]  bar_eff;
    logic [8:0]  bpm_eff;
    logic        main_beat;
    logic [23:0] vol_prod;
    logic [7:0]  vol_raw;
    logic [6:0]  vol_val;
    logic [31:0] tenth_prod;
    logic [4:0]  beat_inc;

    div_req_t    div_req;
    div_rsp_t    div_rsp;

    mbeg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b0;
            bpm_reg     <= 9'd120;
            bar_reg     <= 5'd4;
            accent_reg  <= 7'd76;
            plain_reg   <= 7'd77;
            channel_reg <= 5'd10;
            volume_reg  <= 7'd100;
            instr_reg   <= 7'd0;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_ENABLED:    enabled_reg <= pwdata[0];
                REG_BPM:        bpm_reg     <= pwdata[8:0];
                REG_BAR:        bar_reg     <= pwdata[4:0];
                REG_ACCENT:     accent_reg  <= pwdata[6:0];
                REG_PLAIN:      plain_reg   <= pwdata[6:0];
                REG_CHANNEL:    channel_reg <= pwdata[4:0];
                REG_VOLUME:     volume_reg  <= pwdata[6:0];
                REG_INSTRUMENT: instr_reg   <= pwdata[6:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_ENABLED:    prdata = {31'd0, enabled_reg};
            REG_BPM:        prdata = {23'd0, bpm_reg};
            REG_BAR:        prdata = {27'd0, bar_reg};
            REG_ACCENT:     prdata = {25'd0, accent_reg};
            REG_PLAIN:      prdata = {25'd0, plain_reg};
            REG_CHANNEL:    prdata = {27'd0, channel_reg};
            REG_VOLUME:     prdata = {25'd0, volume_reg};
            REG_INSTRUMENT: prdata = {25'd0, instr_reg};
            default:        prdata = '0;
        endcase
    end

    // derived settings
    always_comb
    begin
        if (bar_reg == 5'd0)
            bar_eff = 5'd1;
        else if (bar_reg > 5'd16)
            bar_eff = 5'd16;
        else
            bar_eff = bar_reg;
        bpm_eff   = (bpm_reg == 9'd0) ? 9'd1 : bpm_reg;
        main_beat = (beat_reg == 4'd1) || (bar_eff == 5'd1);
        // percent*128/100 as (percent*32)/25
        vol_prod  = 24'({volume_reg, 5'b0}) * 24'(VOL_MUL);
        vol_raw   = vol_prod[23:16];
        vol_val   = (vol_raw > 8'd127) ? 7'd127 : vol_raw[6:0];
        tenth_prod = 32'(div_rsp.quotient) * 32'(TENTH_MUL);
        beat_inc  = {1'b0, beat_reg} + 5'd1;
    end

    // control word decode
    assign uw        = ucode(pc_reg);
    assign tick_take = (pc_reg == STEP_IDLE) && tick_valid;
    assign tick_stall = pc_reg != STEP_IDLE;
    assign out_free  = !evt_valid_reg || !evt_stall;
    assign emit      = (uw.op == OP_EMIT) && out_free;

    always_comb
    begin
        case (uw.cond)
            COND_NEVER:    cond_true = 1'b0;
            COND_ALWAYS:   cond_true = 1'b1;
            COND_NO_ITEM:  cond_true = !tick_valid;
            COND_DISABLED: cond_true = !enabled_reg;
            COND_NO_PROG:  cond_true = !prog_reg;
            COND_NO_STOP:  cond_true = !stop_reg;
            COND_NO_BEAT:  cond_true = !beat_hit_reg;
            COND_DIV_BUSY: cond_true = div_rsp.busy;
            default:       cond_true = 1'b0;
        endcase

        if ((uw.op == OP_EMIT) && !out_free)
            pc_next = pc_reg;
        else if (cond_true)
            pc_next = uw.target;
        else
            pc_next = pc_reg + 5'd1;
    end

    always_comb
    begin
        evt_build = '{event_kind: KIND_LED, event_channel: channel_reg, data_first: 7'd0,
                      data_second: 7'd0, led_level: 9'd0, last: 1'b0};
        case (uw.ev)
            EV_PROGRAM:
            begin
                evt_build.event_kind = KIND_PROGRAM;
                evt_build.data_first = instr_reg;
                evt_build.last       = !stop_reg && !beat_hit_reg;
            end
            EV_OFF_ACCENT:
            begin
                evt_build.event_kind = KIND_NOTE_OFF;
                evt_build.data_first = accent_reg;
            end
            EV_OFF_PLAIN:
            begin
                evt_build.event_kind = KIND_NOTE_OFF;
                evt_build.data_first = plain_reg;
            end
            EV_LED_OFF:
            begin
                evt_build.last = !beat_hit_reg;
            end
            EV_VOLUME:
            begin
                evt_build.event_kind  = KIND_CONTROL;
                evt_build.data_first  = 7'h07;
                evt_build.data_second = vol_val;
            end
            EV_NOTE_ON:
            begin
                evt_build.event_kind  = KIND_NOTE_ON;
                evt_build.data_first  = main_beat ? accent_reg : plain_reg;
                evt_build.data_second = 7'd127;
            end
            EV_LED_BEAT:
            begin
                evt_build.led_level = main_beat ? 9'd256 : 9'd32;
                evt_build.last      = 1'b1;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        div_req.start    = (uw.op == OP_DIV_PERIOD) || (uw.op == OP_DIV_BAR);
        div_req.dividend = (uw.op == OP_DIV_PERIOD) ? BEAT_MS_NUM : {11'd0, beat_inc};
        div_req.divisor  = (uw.op == OP_DIV_PERIOD) ? bpm_eff : {4'd0, bar_eff};
    end

    always_comb
    begin
        time_next       = time_reg;
        loop_next       = loop_reg;
        beat_next       = beat_reg;
        next_beat_next  = next_beat_reg;
        next_stop_next  = next_stop_reg;
        sounding_next   = sounding_reg;
        last_instr_next = last_instr_reg;
        prog_next       = prog_reg;
        stop_next       = stop_reg;
        beat_hit_next   = beat_hit_reg;
        period_next     = period_reg;
        tenth_next      = tenth_reg;
        evt_valid_next  = evt_valid_reg;
        evt_next        = evt_reg;

        if (tick_take)
        begin
            time_next = tick.time_ms;
            loop_next = tick.loop_start_ms;
        end

        if (emit)
        begin
            evt_valid_next = 1'b1;
            evt_next       = evt_build;
        end
        else if (!evt_stall)
        begin
            evt_valid_next = 1'b0;
        end

        case (uw.op)
            OP_EVAL:
            begin
                if (enabled_reg)
                begin
                    prog_next       = ({1'b0, instr_reg} != last_instr_reg)
                                      && (instr_reg != 7'd0);
                    last_instr_next = {1'b0, instr_reg};
                    stop_next       = (time_reg >= next_stop_reg) && sounding_reg;
                    beat_hit_next   = time_reg >= next_beat_reg;
                end
                else
                begin
                    beat_next      = 4'd1;
                    next_beat_next = loop_reg + REARM_MS;
                    next_stop_next = loop_reg + REARM_MS;
                    sounding_next  = 1'b0;
                end
            end
            OP_EMIT:
            begin
                if (emit && (uw.ev == EV_LED_OFF))
                    sounding_next = 1'b0;
            end
            OP_TAKE_PERIOD:
            begin
                period_next = div_rsp.quotient;
                tenth_next  = tenth_prod[31:19];
            end
            OP_SET_TIMES:
            begin
                next_beat_next = time_reg + {16'd0, period_reg};
                next_stop_next = time_reg + {19'd0, tenth_reg};
            end
            OP_SET_BAR:
            begin
                beat_next     = div_rsp.remainder[3:0];
                sounding_next = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg         <= STEP_IDLE;
            beat_reg       <= 4'd1;
            next_beat_reg  <= '0;
            next_stop_reg  <= '0;
            sounding_reg   <= 1'b0;
            last_instr_reg <= 8'd255;
            prog_reg       <= 1'b0;
            stop_reg       <= 1'b0;
            beat_hit_reg   <= 1'b0;
            evt_valid_reg  <= 1'b0;
        end
        else
        begin
            pc_reg         <= pc_next;
            beat_reg       <= beat_next;
            next_beat_reg  <= next_beat_next;
            next_stop_reg  <= next_stop_next;
            sounding_reg   <= sounding_next;
            last_instr_reg <= last_instr_next;
            prog_reg       <= prog_next;
            stop_reg       <= stop_next;
            beat_hit_reg   <= beat_hit_next;
            evt_valid_reg  <= evt_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        time_reg   <= time_next;
        loop_reg   <= loop_next;
        period_reg <= period_next;
        tenth_reg  <= tenth_next;
        evt_reg    <= evt_next;
    end

    assign evt_valid = evt_valid_reg;
    assign evt       = evt_reg;

endmodule

`default_nettype wire

// ----- rtl/core/mbeg_checker.sv -----
`default_nettype none

module mbeg_checker
    import mbeg_pkg::*;
(
    input wire logic  clk,
    input wire logic  rst_n,
    input wire logic  tick_valid,
    input wire logic  tick_stall,
    input wire logic  evt_valid,
    input wire logic  evt_stall,
    input wire evt_t  evt
);

    // an item held back on the output stays offered
    a_evt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && evt_stall |=> evt_valid)
        else $error("event item dropped while stalled");

    // one tick at a time: acceptance closes the input
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        tick_valid && !tick_stall |=> tick_stall)
        else $error("tick input open right after acceptance");

    // only LED items carry a level
    a_led_only: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && (evt.event_kind != KIND_LED) |-> evt.led_level == 9'd0)
        else $error("led level on a non-LED item");

    // note-on always at full velocity, note-off never at full velocity
    a_velocity: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && (evt.event_kind == KIND_NOTE_ON || evt.event_kind == KIND_NOTE_OFF)
        |-> (evt.data_second == 7'd127) == (evt.event_kind == KIND_NOTE_ON))
        else $error("note velocity wrong");

endmodule

bind metronome_beat_event_generator_unit mbeg_checker u_mbeg_checker (.*);

`default_nettype wire
